// ===== src/ufc_pkg.sv =====
`default_nettype none
package ufc_pkg;

    localparam int FRAME_CAPACITY = 100;
    localparam int CNT_W = $clog2(FRAME_CAPACITY + 1);

    localparam logic [15:0] IDLE_TICKS_RESET = 16'd12000;
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] IDLE_MAX = 16'hFFFF;

    localparam logic [1:0] ST_GOOD    = 2'd0;
    localparam logic [1:0] ST_BAD_LEN = 2'd1;
    localparam logic [1:0] ST_BAD_CRC = 2'd2;

    localparam logic REQ_BYTE = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic        valid;
        logic [1:0]  status;
        logic [6:0]  frame_length;
        logic [15:0] command;
        logic [31:0] argument;
    } t_result;

    // CRC-16/CCITT-FALSE, one byte, table-free form
    function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = {crc[7:0], crc[15:8]};
        c = c ^ {8'h00, b};
        c = c ^ {12'h000, c[7:4]};
        c = c ^ {c[3:0], 12'h000};
        c = c ^ {3'b000, c[7:0], 5'b00000};
        return c;
    endfunction

endpackage
`default_nettype wire

// ===== src/ufc_frame_core.sv =====
`default_nettype none
module ufc_frame_core (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_go,
    input  wire logic                  i_req_type,
    input  wire logic [7:0]            i_data_byte,
    input  wire logic [15:0]           i_idle_ticks,
    output ufc_pkg::t_result           o_result
);
    import ufc_pkg::*;

    logic [CNT_W-1:0] r_byte_count, n_byte_count;
    logic [15:0]      r_idle_count, n_idle_count;
    logic             r_timer_running, n_timer_running;
    logic [15:0]      r_crc, n_crc;
    logic [7:0]       r_tail0, n_tail0;
    logic [7:0]       r_tail1, n_tail1;
    logic [7:0]       r_length, n_length;
    logic [15:0]      r_command, n_command;
    logic [31:0]      r_argument, n_argument;

    logic [15:0] idle_inc;
    logic        len_bad;
    logic        crc_bad;

    assign idle_inc = (r_idle_count < IDLE_MAX) ? r_idle_count + 16'd1 : r_idle_count;
    assign len_bad  = (r_length < 8'd2) || ({1'b0, r_length} != 9'(r_byte_count));
    assign crc_bad  = (r_tail0 != r_crc[15:8]) || (r_tail1 != r_crc[7:0]);

    always_comb begin
        n_byte_count    = r_byte_count;
        n_idle_count    = r_idle_count;
        n_timer_running = r_timer_running;
        n_crc           = r_crc;
        n_tail0         = r_tail0;
        n_tail1         = r_tail1;
        n_length        = r_length;
        n_command       = r_command;
        n_argument      = r_argument;
        o_result        = '0;

        if (i_go) begin
            if (i_req_type == REQ_BYTE) begin
                if (r_byte_count < CNT_W'(FRAME_CAPACITY)) begin
                    // CRC trails the stored bytes by two: the tail is the check
                    if (r_byte_count >= CNT_W'(2)) begin
                        n_crc = crc_byte(r_crc, r_tail0);
                    end
                    n_tail0 = r_tail1;
                    n_tail1 = i_data_byte;
                    if (r_byte_count == CNT_W'(1)) begin
                        n_length = i_data_byte;
                    end else if (r_byte_count == CNT_W'(2)) begin
                        n_command[15:8] = i_data_byte;
                    end else if (r_byte_count == CNT_W'(3)) begin
                        n_command[7:0] = i_data_byte;
                    end else if (r_byte_count >= CNT_W'(4) && r_byte_count <= CNT_W'(7)) begin
                        n_argument[8*(2'd3 - r_byte_count[1:0]) +: 8] = i_data_byte;
                    end
                    n_byte_count = r_byte_count + CNT_W'(1);
                end
                n_idle_count    = '0;
                n_timer_running = 1'b1;
            end else if (r_timer_running) begin
                n_idle_count = idle_inc;
                if (idle_inc >= i_idle_ticks) begin
                    n_timer_running = 1'b0;
                    if (r_byte_count != '0) begin
                        o_result.valid        = 1'b1;
                        o_result.frame_length = 7'(r_byte_count);
                        o_result.argument     = r_argument;
                        if (len_bad) begin
                            o_result.status = ST_BAD_LEN;
                        end else if (crc_bad) begin
                            o_result.status = ST_BAD_CRC;
                        end else begin
                            o_result.status  = ST_GOOD;
                            o_result.command = r_command;
                        end
                    end
                    n_byte_count = '0;
                    n_idle_count = '0;
                    n_crc        = CRC_INIT;
                    n_tail0      = '0;
                    n_tail1      = '0;
                    n_length     = '0;
                    n_command    = '0;
                    n_argument   = '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_count    <= '0;
            r_idle_count    <= '0;
            r_timer_running <= 1'b1;
            r_crc           <= CRC_INIT;
            r_tail0         <= '0;
            r_tail1         <= '0;
            r_length        <= '0;
            r_command       <= '0;
            r_argument      <= '0;
        end else begin
            r_byte_count    <= n_byte_count;
            r_idle_count    <= n_idle_count;
            r_timer_running <= n_timer_running;
            r_crc           <= n_crc;
            r_tail0         <= n_tail0;
            r_tail1         <= n_tail1;
            r_length        <= n_length;
            r_command       <= n_command;
            r_argument      <= n_argument;
        end
    end

endmodule
`default_nettype wire

// ===== src/uart_frame_checker.sv =====
`default_nettype none
// channel | handshake                   | payload
// in      | i_in_valid / o_in_ready     | i_req_type, i_data_byte
// out     | o_out_valid / i_out_ready   | o_status, o_frame_length, o_command, o_argument
// cfg     | i_cfg_valid / o_cfg_ready   | i_cfg_idle_ticks
//
// One beat per cycle in; a closing tick's result goes through the input register,
// then the result register, before it shows on the out channel.
// The frame state update and the CRC byte step sit between those two registers.
// Synchronous active-low reset; idle_ticks resets to 12000, timer running, frame empty.
// A held result stalls the input register, which then holds o_in_ready low once full.
module uart_frame_checker (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output      logic        o_in_ready,
    input  wire logic        i_req_type,
    input  wire logic [7:0]  i_data_byte,
    output      logic        o_out_valid,
    input  wire logic        i_out_ready,
    output      logic [1:0]  o_status,
    output      logic [6:0]  o_frame_length,
    output      logic [15:0] o_command,
    output      logic [31:0] o_argument,
    input  wire logic        i_cfg_valid,
    output      logic        o_cfg_ready,
    input  wire logic [15:0] i_cfg_idle_ticks
);
    import ufc_pkg::*;

    logic        r_in_valid;
    logic        r_req_type;
    logic [7:0]  r_data_byte;
    logic [15:0] r_idle_ticks;
    t_result     r_out;
    t_result     core_result;
    logic        go;

    // the stage advances whenever the result register can take what it might produce
    assign go          = r_in_valid && (!r_out.valid || i_out_ready);
    assign o_in_ready  = !r_in_valid || go;
    assign o_cfg_ready = 1'b1;

    ufc_frame_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_go         (go),
        .i_req_type   (r_req_type),
        .i_data_byte  (r_data_byte),
        .i_idle_ticks (r_idle_ticks),
        .o_result     (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_idle_ticks <= IDLE_TICKS_RESET;
            r_out.valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_idle_ticks <= i_cfg_idle_ticks;
            end
            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end
            if (go && core_result.valid) begin
                r_out.valid        <= 1'b1;
                r_out.status       <= core_result.status;
                r_out.frame_length <= core_result.frame_length;
                r_out.command      <= core_result.command;
                r_out.argument     <= core_result.argument;
            end else if (i_out_ready) begin
                r_out.valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_req_type  <= i_req_type;
            r_data_byte <= i_data_byte;
        end
    end

    assign o_out_valid    = r_out.valid;
    assign o_status       = r_out.status;
    assign o_frame_length = r_out.frame_length;
    assign o_command      = r_out.command;
    assign o_argument     = r_out.argument;

endmodule
`default_nettype wire

// ===== verif/tb_uart_frame_checker.sv =====
module tb_uart_frame_checker;
    timeunit 1ns;
    timeprecision 1ps;

    import ufc_pkg::*;

    localparam int LIMIT_CYCLES = 1_000_000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 400;

    typedef enum logic [1:0] {ROW_BYTE, ROW_TICK, ROW_CRC_HI, ROW_CRC_LO} t_row_kind;

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  length;
        logic [15:0] command;
        logic [31:0] argument;
    } t_frame_res;

    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  value;
        logic        fixed;
        t_frame_res  res;
    } t_stim_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_ready;
    logic        i_req_type = REQ_BYTE;
    logic [7:0]  i_data_byte = 8'h00;
    logic        o_out_valid;
    logic        i_out_ready = 1'b0;
    logic [1:0]  o_status;
    logic [6:0]  o_frame_length;
    logic [15:0] o_command;
    logic [31:0] o_argument;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [15:0] i_cfg_idle_ticks = 16'h0000;

    uart_frame_checker DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_req_type       (i_req_type),
        .i_data_byte      (i_data_byte),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_status         (o_status),
        .o_frame_length   (o_frame_length),
        .o_command        (o_command),
        .o_argument       (o_argument),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_idle_ticks (i_cfg_idle_ticks)
    );

    always #5 i_clk = ~i_clk;

    // Frame checker mirror
    logic [15:0] m_idle_ticks = IDLE_TICKS_RESET;
    int          m_count = 0;
    logic [15:0] m_idle = 16'h0000;
    logic        m_run = 1'b1;
    logic [15:0] m_crc = CRC_INIT;
    logic [7:0]  m_tail [2] = '{8'h00, 8'h00};
    logic [7:0]  m_len = 8'h00;
    logic [15:0] m_cmd = 16'h0000;
    logic [31:0] m_arg = 32'h0;

    t_frame_res  pending_frames [$];
    int          errors = 0;
    int          rand_items = 0;
    int          cycle_count = 0;
    bit          no_gaps = 1'b0;
    bit          long_hold_req = 1'b0;

    t_stim_row directed_rows [0:28] = '{
        '{ROW_TICK,   8'h00, 1'b0, '0},      // empty frame closes silently
        '{ROW_BYTE,   8'h00, 1'b0, '0},
        '{ROW_TICK,   8'h00, 1'b1, '{ST_BAD_LEN, 7'd1, 16'h0000, 32'h0}},
        '{ROW_BYTE,   8'hFF, 1'b0, '0},
        '{ROW_BYTE,   8'h02, 1'b0, '0},
        '{ROW_TICK,   8'hFF, 1'b1, '{ST_BAD_CRC, 7'd2, 16'h0000, 32'h0}},
        '{ROW_BYTE,   8'h12, 1'b0, '0},
        '{ROW_BYTE,   8'h0A, 1'b0, '0},
        '{ROW_BYTE,   8'hAB, 1'b0, '0},
        '{ROW_BYTE,   8'hCD, 1'b0, '0},
        '{ROW_BYTE,   8'hDE, 1'b0, '0},
        '{ROW_BYTE,   8'hAD, 1'b0, '0},
        '{ROW_BYTE,   8'hBE, 1'b0, '0},
        '{ROW_BYTE,   8'hEF, 1'b0, '0},
        '{ROW_CRC_HI, 8'h00, 1'b0, '0},
        '{ROW_CRC_LO, 8'h00, 1'b0, '0},
        '{ROW_TICK,   8'h55, 1'b1, '{ST_GOOD, 7'd10, 16'hABCD, 32'hDEADBEEF}},
        '{ROW_TICK,   8'hAA, 1'b0, '0},
        '{ROW_BYTE,   8'h01, 1'b0, '0},
        '{ROW_BYTE,   8'h05, 1'b0, '0},
        '{ROW_BYTE,   8'hFF, 1'b0, '0},
        '{ROW_BYTE,   8'h00, 1'b0, '0},
        '{ROW_TICK,   8'h00, 1'b1, '{ST_BAD_LEN, 7'd4, 16'h0000, 32'h0}},
        '{ROW_BYTE,   8'h00, 1'b0, '0},
        '{ROW_BYTE,   8'h05, 1'b0, '0},
        '{ROW_BYTE,   8'h11, 1'b0, '0},
        '{ROW_BYTE,   8'h22, 1'b0, '0},
        '{ROW_BYTE,   8'h33, 1'b0, '0},
        '{ROW_TICK,   8'h00, 1'b0, '0}
    };

    // bitwise CCITT, MSB first
    function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++)
            c = c[15] ? ((c << 1) ^ 16'h1021) : (c << 1);
        return c;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 65)
            return 0;
        else if (r < 92)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    task automatic predict_item(input logic req, input logic [7:0] b,
                                output bit closed, output t_frame_res res);
        closed = 1'b0;
        res = '0;
        if (req == REQ_BYTE) begin
            if (m_count < FRAME_CAPACITY) begin
                if (m_count >= 2)
                    m_crc = crc16_step(m_crc, m_tail[0]);
                m_tail[0] = m_tail[1];
                m_tail[1] = b;
                if (m_count == 1)
                    m_len = b;
                else if (m_count == 2)
                    m_cmd[15:8] = b;
                else if (m_count == 3)
                    m_cmd[7:0] = b;
                else if (m_count >= 4 && m_count <= 7)
                    m_arg[8*(7-m_count) +: 8] = b;
                m_count++;
            end
            m_idle = 16'h0000;
            m_run = 1'b1;
        end else if (m_run) begin
            if (m_idle != IDLE_MAX)
                m_idle++;
            if (m_idle >= m_idle_ticks) begin
                m_run = 1'b0;
                if (m_count != 0) begin
                    closed = 1'b1;
                    res.length = m_count[6:0];
                    res.argument = m_arg;
                    if (m_len < 2 || m_len != m_count)
                        res.status = ST_BAD_LEN;
                    else if ({m_tail[0], m_tail[1]} != m_crc)
                        res.status = ST_BAD_CRC;
                    else begin
                        res.status = ST_GOOD;
                        res.command = m_cmd;
                    end
                end
                m_count = 0;
                m_idle = 16'h0000;
                m_crc = CRC_INIT;
                m_tail[0] = 8'h00;
                m_tail[1] = 8'h00;
                m_len = 8'h00;
                m_cmd = 16'h0000;
                m_arg = 32'h0;
            end
        end
    endtask

    task automatic send_item(input logic req, input logic [7:0] b,
                             input bit fixed, input t_frame_res fixed_res);
        bit closed;
        t_frame_res res;
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_req_type <= req;
        i_data_byte <= b;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        predict_item(req, b, closed, res);
        if (fixed)
            pending_frames.push_back(fixed_res);
        else if (closed)
            pending_frames.push_back(res);
    endtask

    // only while nothing is in flight
    task automatic set_idle(input logic [15:0] v);
        i_in_valid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_idle_ticks <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        m_idle_ticks = v;
    endtask

    task automatic send_frame();
        logic [7:0]  fb [$];
        logic [15:0] c;
        int n, kind, ticks, lim, idx;
        kind = $urandom_range(0, 99);
        if (kind < 80) begin
            if ($urandom_range(0, 39) == 0)
                n = FRAME_CAPACITY;
            else if ($urandom_range(0, 14) == 0)
                n = $urandom_range(13, FRAME_CAPACITY - 1);
            else
                n = $urandom_range(4, 12);
            fb.push_back(8'($urandom_range(0, 255)));
            fb.push_back(8'(n));
            while (fb.size() < n - 2)
                fb.push_back(8'($urandom_range(0, 255)));
            c = CRC_INIT;
            foreach (fb[k])
                c = crc16_step(c, fb[k]);
            fb.push_back(c[15:8]);
            fb.push_back(c[7:0]);
            if (kind >= 55 && kind < 70) begin
                idx = n - 1 - $urandom_range(0, 1);
                fb[idx] = fb[idx] ^ 8'(1 << $urandom_range(0, 7));
            end else if (kind >= 70) begin
                fb[1] = fb[1] ^ 8'($urandom_range(1, 255));
            end
            // bytes past capacity get dropped
            if (n == FRAME_CAPACITY)
                repeat ($urandom_range(0, 4)) fb.push_back(8'($urandom_range(0, 255)));
        end else begin
            repeat ($urandom_range(1, 10)) fb.push_back(8'($urandom_range(0, 255)));
        end
        foreach (fb[k]) begin
            send_item(REQ_BYTE, fb[k], 1'b0, '0);
            rand_items++;
        end
        lim = (m_idle_ticks == 0) ? 1 : int'(m_idle_ticks);
        // now and then stop short so the next frame runs on into this one
        if ($urandom_range(0, 4) != 0)
            ticks = lim + $urandom_range(0, 2);
        else
            ticks = $urandom_range(0, lim - 1);
        repeat (ticks) begin
            send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
            rand_items++;
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        t_frame_res want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_frames.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %h %h %h %h", $time,
                         o_status, o_frame_length, o_command, o_argument);
                errors++;
            end else begin
                want = pending_frames.pop_front();
                check_field("status", 32'(want.status), 32'(o_status));
                check_field("frame_length", 32'(want.length), 32'(o_frame_length));
                check_field("command", 32'(want.command), 32'(o_command));
                check_field("argument", want.argument, o_argument);
            end
        end
    end

    // result side backpressure
    initial begin
        int stall_left;
        int r;
        stall_left = 0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left = HOLD_CYCLES;
                i_out_ready <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (no_gaps || r < 70) begin
                    i_out_ready <= 1'b1;
                end else if (r < 95) begin
                    i_out_ready <= 1'b0;
                    stall_left = $urandom_range(0, 3);
                end else begin
                    i_out_ready <= 1'b0;
                    stall_left = $urandom_range(10, 40);
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: timeout, %0d results outstanding", $time, pending_frames.size());
        $display("== FAIL ==");
        $finish;
    end

    initial begin
        logic [7:0]  b;
        logic [15:0] tx_crc;
        logic [15:0] crc_hold;
        logic [15:0] v;
        int start_items;
        int phase;
        tx_crc = CRC_INIT;
        crc_hold = CRC_INIT;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset setting: a short run of ticks stays below the reset threshold
        no_gaps = 1'b1;
        repeat (10)
            send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
        no_gaps = 1'b0;

        set_idle(16'd1);
        foreach (directed_rows[i]) begin
            case (directed_rows[i].kind)
                ROW_CRC_HI: begin
                    crc_hold = tx_crc;
                    b = crc_hold[15:8];
                end
                ROW_CRC_LO: b = crc_hold[7:0];
                default: b = directed_rows[i].value;
            endcase
            send_item((directed_rows[i].kind == ROW_TICK) ? REQ_TICK : REQ_BYTE, b,
                      directed_rows[i].fixed, directed_rows[i].res);
            if (directed_rows[i].kind == ROW_TICK)
                tx_crc = CRC_INIT;
            else
                tx_crc = crc16_step(tx_crc, b);
        end

        // lowering the threshold below the idle count closes on the next tick
        set_idle(16'd10);
        send_item(REQ_BYTE, 8'h07, 1'b0, '0);
        repeat (5) send_item(REQ_TICK, 8'h00, 1'b0, '0);
        set_idle(16'd3);
        send_item(REQ_TICK, 8'hFF, 1'b0, '0);

        start_items = rand_items;
        phase = 0;
        while (rand_items - start_items < 1000) begin
            case (phase % 6)
                0: v = 16'd1;
                1: v = 16'd0;
                2: v = 16'($urandom_range(2, 6));
                3: v = 16'($urandom_range(7, 40));
                4: v = 16'd2;
                default: v = 16'($urandom_range(1, 12));
            endcase
            set_idle(v);
            no_gaps = (phase % 6 == 4);
            if (phase == 0) begin
                // results pile up behind a held output until the input stalls
                long_hold_req = 1'b1;
                repeat (15) begin
                    send_item(REQ_BYTE, 8'($urandom_range(0, 255)), 1'b0, '0);
                    send_item(REQ_TICK, 8'($urandom_range(0, 255)), 1'b0, '0);
                end
            end
            repeat (8) send_frame();
            phase++;
        end

        i_in_valid <= 1'b0;
        no_gaps = 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
